@@ rtl/ddo_pkg.sv @@
`default_nettype none
package ddo_pkg;

  localparam int CORDIC_STEPS_DEF = 16;
  localparam int ANGLE_BITS_DEF   = 16;
  localparam int POS_BITS_DEF     = 32;

  localparam int RAD_W  = 20;
  localparam int SPD_W  = 16;
  localparam int DT_W   = 16;
  localparam int OUT_W  = 32;
  localparam int ANG_W  = 16;
  localparam int Q14_W  = 16;
  localparam int CFG_IDX_W = 8;
  localparam int CFG_DAT_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_RADIUS = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TRACK  = 8'd1;

  localparam logic [RAD_W-1:0] RADIUS_RST = 20'd50000;
  localparam logic [RAD_W-1:0] TRACK_RST  = 20'd180000;

  localparam logic [31:0] TWO_PI_MICRO = 32'd6283185;
  localparam logic [31:0] DIST_DIV     = 32'd512000000;
  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

  typedef struct packed {
    logic signed [SPD_W-1:0] left_wheel_speed;
    logic signed [SPD_W-1:0] right_wheel_speed;
    logic [DT_W-1:0]         elapsed_time_us;
  } in_word_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] position_x_um;
    logic signed [OUT_W-1:0] position_y_um;
    logic [ANG_W-1:0]        heading_angle;
    logic signed [Q14_W-1:0] quat_w;
    logic signed [Q14_W-1:0] quat_z;
  } out_word_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_DAT_W-1:0] data;
  } cfg_word_t;

  function automatic logic [31:0] atan_turn(input logic [4:0] i);
    logic [31:0] r;
    begin
      unique case (i)
        5'd0:  r = 32'd536870912;
        5'd1:  r = 32'd316933406;
        5'd2:  r = 32'd167458907;
        5'd3:  r = 32'd85004756;
        5'd4:  r = 32'd42667331;
        5'd5:  r = 32'd21354465;
        5'd6:  r = 32'd10679838;
        5'd7:  r = 32'd5340245;
        5'd8:  r = 32'd2670163;
        5'd9:  r = 32'd1335087;
        5'd10: r = 32'd667544;
        5'd11: r = 32'd333772;
        5'd12: r = 32'd166886;
        5'd13: r = 32'd83443;
        5'd14: r = 32'd41722;
        5'd15: r = 32'd20861;
        5'd16: r = 32'd10430;
        5'd17: r = 32'd5215;
        5'd18: r = 32'd2608;
        5'd19: r = 32'd1304;
        5'd20: r = 32'd652;
        5'd21: r = 32'd326;
        5'd22: r = 32'd163;
        5'd23: r = 32'd81;
        default: r = 32'd0;
      endcase
      return r;
    end
  endfunction

endpackage
`default_nettype wire

@@ rtl/diff_drive_odometry_core.sv @@
// channel | direction | signals
// in      | input     | in_valid, in_ready, in_data (ddo_pkg::in_word_t)
// out     | output    | out_valid, out_ready, out_data (ddo_pkg::out_word_t)
// cfg     | input     | cfg_valid, cfg_ready, cfg_data (ddo_pkg::cfg_word_t)
//
// one word in flight; an accepted word passes through two bit-serial products,
// three restoring divides (the heading divides are skipped when the track is
// zero), two passes of the shared cordic, two position multiplies and the load
// of the output register. a new word is taken once the previous result is
// loaded, so a stall on out only holds the next word in S_OUT.
// rst_n is synchronous; it clears pose, registers to their reset values, control.
`default_nettype none
module diff_drive_odometry_core #(
  parameter int CORDIC_STEPS = ddo_pkg::CORDIC_STEPS_DEF,
  parameter int ANGLE_BITS   = ddo_pkg::ANGLE_BITS_DEF,
  parameter int POS_BITS     = ddo_pkg::POS_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire ddo_pkg::in_word_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output ddo_pkg::out_word_t      out_data,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire ddo_pkg::cfg_word_t cfg_data
);

  // product radius*|v|*dt: 20+17+16 = 53 bits, plus headroom for shift
  localparam int PW   = 64;
  localparam int SH   = ANGLE_BITS - 8;
  localparam int CW   = 34;
  localparam int SW   = $clog2(CORDIC_STEPS + 1);
  localparam int CNTW = 7;
  localparam int MW   = 36;  // multiplier for d*c: |d| < 2^35
  localparam int OW   = ddo_pkg::OUT_W;
  localparam int AW   = ddo_pkg::ANG_W;
  localparam logic signed [POS_BITS-1:0] PMAX = {1'b0, {(POS_BITS-1){1'b1}}};
  localparam logic signed [POS_BITS-1:0] PMIN = {1'b1, {(POS_BITS-1){1'b0}}};

  typedef enum logic [10:0] {
    S_IDLE  = 11'b00000000001,
    S_MUL   = 11'b00000000010,
    S_DDIV  = 11'b00000000100,
    S_HDIV  = 11'b00000001000,
    S_HDIV2 = 11'b00000010000,
    S_COR1  = 11'b00000100000,
    S_MULX  = 11'b00001000000,
    S_MULY  = 11'b00010000000,
    S_COR2  = 11'b00100000000,
    S_OUT   = 11'b01000000000,
    S_MUL2  = 11'b10000000000
  } state_t;

  state_t state_r, state_nxt;

  logic [ddo_pkg::RAD_W-1:0] radius_r, track_r;
  logic signed [POS_BITS-1:0] pos_x_r, pos_y_r;
  logic [ANGLE_BITS-1:0] heading_r;

  logic [16:0] mdif_r;
  logic        sneg_r, dneg_r;
  logic [ddo_pkg::DT_W-1:0] dt_r;
  logic [CNTW-1:0] cnt_r;

  // shift-add multiplier: acc += mcand when multiplier lsb set
  logic [PW-1:0] acc_r, mcand_r, mplier_r;
  logic [PW-1:0] a_sum_r, a_dif_r;
  // restoring divider
  logic [PW-1:0] rem_r, quo_r, den_r, num_r;
  logic [34:0] dmag_r;
  logic [PW-1:0] q1_r;

  logic signed [CW-1:0] cx_r, cy_r;
  logic signed [32:0]   cz_r;
  logic [SW-1:0]        step_r;
  logic                 flip_r;
  logic signed [CW-1:0] cos_r, sin_r;

  logic signed [MW-1:0]   d_r;
  logic signed [MW+CW-1:0] prod_r;
  logic signed [CW-1:0]   mc_r;

  logic out_valid_r;
  ddo_pkg::out_word_t out_r;

  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // cordic step
  logic signed [CW-1:0] cx_sh, cy_sh;
  logic [31:0] atv;
  always_comb begin
    cx_sh = cx_r >>> step_r;
    cy_sh = cy_r >>> step_r;
    atv   = ddo_pkg::atan_turn(5'(step_r));
  end

  logic [PW-1:0] div_trial;
  logic [PW-1:0] rem_sh;
  always_comb begin
    rem_sh    = {rem_r[PW-2:0], num_r[PW-1]};
    div_trial = rem_sh - den_r;
  end

  logic signed [MW+CW-1:0] prod_add;
  logic signed [POS_BITS+1:0] step_ext, psum;
  logic signed [POS_BITS-1:0] psat;
  logic signed [POS_BITS-1:0] pcur;
  always_comb begin
    prod_add = prod_r + (MW+CW)'(64'sd1 <<< 29);
    step_ext = (POS_BITS+2)'(prod_add >>> 30);
    pcur     = (state_r == S_MULX) ? pos_x_r : pos_y_r;
    psum     = (POS_BITS+2)'(pcur) + step_ext;
    if (psum > (POS_BITS+2)'(PMAX))      psat = PMAX;
    else if (psum < (POS_BITS+2)'(PMIN)) psat = PMIN;
    else                                 psat = psum[POS_BITS-1:0];
  end

  function automatic logic signed [ddo_pkg::Q14_W-1:0] to_q14(input logic signed [CW-1:0] v);
    logic signed [CW:0] r;
    begin
      r = (CW+1)'((v + CW'(32768)) >>> 16);
      if (r > 16384)       return 16'sd16384;
      else if (r < -16384) return -16'sd16384;
      else                 return r[15:0];
    end
  endfunction

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (in_valid) state_nxt = S_MUL;
      S_MUL:   if (cnt_r == CNTW'(52)) state_nxt = S_MUL2;
      S_MUL2:  if (cnt_r == CNTW'(52)) state_nxt = S_DDIV;
      S_DDIV:  if (cnt_r == CNTW'(PW-1))
                 state_nxt = (track_r != '0) ? S_HDIV : S_HDIV2;
      S_HDIV:  if (cnt_r == CNTW'(PW-1)) state_nxt = S_HDIV2;
      S_HDIV2: if (cnt_r == CNTW'(PW-1) || track_r == '0) state_nxt = S_COR1;
      S_COR1:  if (step_r == SW'(CORDIC_STEPS)) state_nxt = S_MULX;
      S_MULX:  if (cnt_r == CNTW'(MW)) state_nxt = S_MULY;
      S_MULY:  if (cnt_r == CNTW'(MW)) state_nxt = S_COR2;
      S_COR2:  if (step_r == SW'(CORDIC_STEPS)) state_nxt = S_OUT;
      S_OUT:   if (!out_valid_r || out_ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      radius_r    <= ddo_pkg::RADIUS_RST;
      track_r     <= ddo_pkg::TRACK_RST;
      pos_x_r     <= '0;
      pos_y_r     <= '0;
      heading_r   <= '0;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
      step_r      <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid) begin
        if (cfg_data.index == ddo_pkg::REG_RADIUS) radius_r <= cfg_data.data[19:0];
        else if (cfg_data.index == ddo_pkg::REG_TRACK) track_r <= cfg_data.data[19:0];
      end
      if (out_valid_r && out_ready) out_valid_r <= 1'b0;
      cnt_r <= (state_nxt != state_r) ? '0 : cnt_r + 1'b1;

      unique case (state_r)
        S_IDLE: if (in_valid) begin
          logic signed [16:0] s, e;
          s = 17'(in_data.left_wheel_speed) + 17'(in_data.right_wheel_speed);
          e = 17'(in_data.right_wheel_speed) - 17'(in_data.left_wheel_speed);
          sneg_r  <= s[16];
          dneg_r  <= e[16];
          mdif_r  <= e[16] ? 17'(-e) : e;
          dt_r    <= in_data.elapsed_time_us;
          acc_r   <= '0;
          mcand_r <= PW'(radius_r) * PW'(in_data.elapsed_time_us);
          mplier_r <= PW'($unsigned(s[16] ? 17'(-s) : s));
        end
        S_MUL: begin
          // radius*dt preloaded (36 bits, one narrow product); then serial by |S|
          if (mplier_r[0]) acc_r <= acc_r + mcand_r;
          mcand_r  <= mcand_r << 1;
          mplier_r <= mplier_r >> 1;
          if (cnt_r == CNTW'(52)) begin
            a_sum_r  <= mplier_r[0] ? acc_r + mcand_r : acc_r;
            acc_r    <= '0;
            mcand_r  <= PW'(radius_r) * PW'(dt_r);
            mplier_r <= PW'(mdif_r);
          end
        end
        S_MUL2: begin
          if (mplier_r[0]) acc_r <= acc_r + mcand_r;
          mcand_r  <= mcand_r << 1;
          mplier_r <= mplier_r >> 1;
          if (cnt_r == CNTW'(52)) begin
            a_dif_r <= mplier_r[0] ? acc_r + mcand_r : acc_r;
            // distance: (2a+DIV)/(2*DIV)
            num_r <= (a_sum_r << 1) + PW'(ddo_pkg::DIST_DIV);
            den_r <= PW'(ddo_pkg::DIST_DIV) << 1;
            rem_r <= '0;
            quo_r <= '0;
          end
        end
        S_DDIV, S_HDIV, S_HDIV2: begin
          if (!(state_r == S_HDIV2 && track_r == '0)) begin
            if (!div_trial[PW-1]) begin
              rem_r <= div_trial;
              quo_r <= {quo_r[PW-2:0], 1'b1};
            end else begin
              rem_r <= rem_sh;
              quo_r <= {quo_r[PW-2:0], 1'b0};
            end
            num_r <= num_r << 1;
          end
          if (cnt_r == CNTW'(PW-1)) begin
            rem_r <= '0;
            quo_r <= '0;
            unique case (state_r)
              S_DDIV: begin
                dmag_r <= 35'({quo_r[PW-2:0], !div_trial[PW-1]});
                num_r  <= a_dif_r;
                den_r  <= PW'(ddo_pkg::TWO_PI_MICRO) * PW'(track_r);
              end
              S_HDIV: begin
                q1_r  <= {quo_r[PW-2:0], !div_trial[PW-1]};
                num_r <= ((div_trial[PW-1] ? rem_sh : div_trial) << (SH + 1)) + den_r;
                den_r <= den_r << 1;
              end
              default: begin
                logic [PW-1:0] q2;
                logic [ANGLE_BITS-1:0] st;
                q2 = {quo_r[PW-2:0], !div_trial[PW-1]};
                st = ANGLE_BITS'((q1_r << SH) + q2);
                heading_r <= dneg_r ? heading_r - st : heading_r + st;
              end
            endcase
          end
          if (state_r == S_HDIV2 && state_nxt == S_COR1) begin
            logic [31:0] a;
            logic [PW-1:0] q2;
            logic [ANGLE_BITS-1:0] st, hn;
            q2 = {quo_r[PW-2:0], !div_trial[PW-1]};
            st = ANGLE_BITS'((q1_r << SH) + q2);
            hn = (track_r == '0) ? heading_r : (dneg_r ? heading_r - st : heading_r + st);
            heading_r <= hn;
            a = 32'(hn) << (32 - ANGLE_BITS);
            // folded angle keeps bit 30 as its sign
            flip_r <= a[31] ^ a[30];
            cz_r   <= $signed({a[30], a[30], a[30:0]});
            cx_r   <= ddo_pkg::CORDIC_GAIN;
            cy_r   <= '0;
            step_r <= '0;
          end
        end
        S_COR1, S_COR2: begin
          if (step_r != SW'(CORDIC_STEPS)) begin
            if (!cz_r[32]) begin
              cx_r <= cx_r - cy_sh; cy_r <= cy_r + cx_sh;
              cz_r <= cz_r - $signed({1'b0, atv});
            end else begin
              cx_r <= cx_r + cy_sh; cy_r <= cy_r - cx_sh;
              cz_r <= cz_r + $signed({1'b0, atv});
            end
            step_r <= step_r + 1'b1;
          end else begin
            cos_r <= flip_r ? -cx_r : cx_r;
            sin_r <= flip_r ? -cy_r : cy_r;
            if (state_r == S_COR1) begin
              d_r    <= sneg_r ? -MW'(dmag_r) : MW'(dmag_r);
              mc_r   <= flip_r ? -cx_r : cx_r;
              prod_r <= '0;
            end
          end
        end
        S_MULX, S_MULY: begin
          // serial signed multiply d*c, lsb of d first, sign bit subtracted
          if (cnt_r != CNTW'(MW)) begin
            logic signed [MW+CW-1:0] pp;
            pp = (MW+CW)'(mc_r) <<< cnt_r;
            if (d_r[cnt_r[5:0]])
              prod_r <= (cnt_r == CNTW'(MW-1)) ? prod_r - pp : prod_r + pp;
          end else begin
            if (state_r == S_MULX) begin
              pos_x_r <= psat;
              mc_r    <= sin_r;
              prod_r  <= '0;
            end else begin
              logic [31:0] a;
              pos_y_r <= psat;
              a = (32'(heading_r) << (32 - ANGLE_BITS)) >> 1;
              flip_r <= a[31] ^ a[30];
              cz_r   <= $signed({a[30], a[30], a[30:0]});
              cx_r   <= ddo_pkg::CORDIC_GAIN;
              cy_r   <= '0;
              step_r <= '0;
            end
          end
        end
        S_OUT: if (!out_valid_r || out_ready) begin
          // load only once the output register is free
          out_valid_r <= 1'b1;
          out_r.position_x_um <= OW'(pos_x_r);
          out_r.position_y_um <= OW'(pos_y_r);
          out_r.heading_angle <= AW'(heading_r);
          out_r.quat_w <= to_q14(cos_r);
          out_r.quat_z <= to_q14(sin_r);
        end
        default: ;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n) in_ready |-> !(state_r != S_IDLE))
    else $error("ready outside idle");
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
    else $error("result changed while stalled");
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == S_MUL))
    else $error("accepted word did not start");

endmodule
`default_nettype wire

@@ bench/diff_drive_odometry_core_tb.sv @@
`timescale 1ns / 100ps
`default_nettype none
module diff_drive_odometry_core_tb;

  localparam logic [ddo_pkg::CFG_IDX_W-1:0] REG_UNUSED = 8'hA5;
  localparam int IDLE_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 600;
  localparam int LONG_HOLD = 800;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  ddo_pkg::in_word_t in_data;
  logic out_valid;
  logic out_ready;
  ddo_pkg::out_word_t out_data;
  logic cfg_valid;
  logic cfg_ready;
  ddo_pkg::cfg_word_t cfg_data;

  diff_drive_odometry_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  // pose tracker state
  longint unsigned radius_um;
  longint unsigned track_um;
  longint pose_x;
  longint pose_y;
  logic [ddo_pkg::ANG_W-1:0] pose_heading;
  longint arctan_turn32 [16] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772,
    166886, 83443, 41722, 20861
  };

  ddo_pkg::out_word_t pose_q[$];
  int fail_count;
  int mismatch_count;
  int hold_request;
  int idle_cycles;

  function automatic void rotate_unit(input logic [31:0] ang, output longint c,
                                      output longint s);
    logic [31:0] a;
    logic [31:0] t;
    logic flip;
    longint x;
    longint y;
    longint z;
    longint dx;
    longint dy;
    a = ang;
    t = ang + 32'h4000_0000;
    flip = t[31];
    if (flip) begin
      a = ang + 32'h8000_0000;
    end
    x = 652032874;
    y = 0;
    z = longint'($signed(a));
    for (int i = 0; i < 16; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx;
        y = y + dy;
        z = z - arctan_turn32[i];
      end else begin
        x = x + dx;
        y = y - dy;
        z = z + arctan_turn32[i];
      end
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  function automatic longint clamp_pos(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic logic [ddo_pkg::Q14_W-1:0] half_turn_q14(input longint v);
    longint r;
    r = (v + 32768) >>> 16;
    if (r > 16384) r = 16384;
    if (r < -16384) r = -16384;
    return r[ddo_pkg::Q14_W-1:0];
  endfunction

  function automatic ddo_pkg::out_word_t advance_pose(input ddo_pkg::in_word_t w);
    longint wl;
    longint wr;
    longint sum;
    longint dif;
    longint msum;
    longint mdif;
    longint dt;
    longint a;
    longint d;
    longint den;
    longint num;
    longint q1;
    longint r1;
    longint q2;
    longint stepv;
    longint c;
    longint s;
    logic [31:0] a32;
    ddo_pkg::out_word_t r;
    wl = longint'($signed(w.left_wheel_speed));
    wr = longint'($signed(w.right_wheel_speed));
    dt = longint'(w.elapsed_time_us);
    sum = wl + wr;
    dif = wr - wl;
    msum = sum < 0 ? -sum : sum;
    mdif = dif < 0 ? -dif : dif;
    a = longint'(radius_um) * msum * dt;
    d = (2 * a + 512000000) / 1024000000;
    if (sum < 0) d = -d;
    if (track_um != 0) begin
      den = 6283185 * longint'(track_um);
      num = longint'(radius_um) * mdif * dt;
      q1 = num / den;
      r1 = num % den;
      q2 = (2 * (r1 << 8) + den) / (2 * den);
      stepv = (q1 << 8) + q2;
      if (dif < 0) pose_heading = pose_heading - stepv[ddo_pkg::ANG_W-1:0];
      else pose_heading = pose_heading + stepv[ddo_pkg::ANG_W-1:0];
    end
    a32 = {pose_heading, 16'h0000};
    rotate_unit(a32, c, s);
    pose_x = clamp_pos(pose_x + ((d * c + (64'sd1 <<< 29)) >>> 30));
    pose_y = clamp_pos(pose_y + ((d * s + (64'sd1 <<< 29)) >>> 30));
    rotate_unit(a32 >> 1, c, s);
    r.position_x_um = pose_x[31:0];
    r.position_y_um = pose_y[31:0];
    r.heading_angle = pose_heading;
    r.quat_w = half_turn_q14(c);
    r.quat_z = half_turn_q14(s);
    return r;
  endfunction

  task automatic send_tick(input ddo_pkg::in_word_t w);
    int gap;
    gap = $urandom_range(0, 4);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    do @(posedge clk); while (!in_ready);
    pose_q.push_back(advance_pose(w));
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pose_q.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  task automatic write_reg(input logic [ddo_pkg::CFG_IDX_W-1:0] idx,
                           input logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_data <= '{index: idx, data: val};
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == ddo_pkg::REG_RADIUS) radius_um = val[ddo_pkg::RAD_W-1:0];
    else if (idx == ddo_pkg::REG_TRACK) track_um = val[ddo_pkg::RAD_W-1:0];
    @(posedge clk);
  endtask

  function automatic ddo_pkg::in_word_t mk_tick(input int l, input int r, input int t);
    ddo_pkg::in_word_t w;
    w.left_wheel_speed = l[15:0];
    w.right_wheel_speed = r[15:0];
    w.elapsed_time_us = t[15:0];
    return w;
  endfunction

  function automatic ddo_pkg::in_word_t rand_tick();
    ddo_pkg::in_word_t w;
    w = 48'({$urandom, $urandom});
    // mostly realistic short ticks, some wide open
    if ($urandom_range(0, 3) != 0) w.elapsed_time_us = 16'($urandom_range(0, 12000));
    if ($urandom_range(0, 7) == 0) w.right_wheel_speed = w.left_wheel_speed;
    if ($urandom_range(0, 7) == 0) w.right_wheel_speed = -w.left_wheel_speed;
    return w;
  endfunction

  task automatic test_directed_defaults();
    send_tick(mk_tick(0, 0, 0));
    send_tick(mk_tick(256, 256, 10000));
    send_tick(mk_tick(32767, 32767, 65535));
    send_tick(mk_tick(-32768, -32768, 65535));
    send_tick(mk_tick(-32768, 32767, 65535));
    send_tick(mk_tick(32767, -32768, 65535));
    send_tick(mk_tick(1000, 2000, 0));
    send_tick(mk_tick(-1, 1, 1));
    send_tick(mk_tick(0, 32767, 40000));
    send_tick(mk_tick(-32768, 0, 40000));
    send_tick(mk_tick(12345, -23456, 54321));
    wait_drained();
  endtask

  task automatic test_config_extremes();
    write_reg(ddo_pkg::REG_RADIUS, 32'h0000_0001);
    write_reg(ddo_pkg::REG_TRACK, 32'h0000_0001);
    send_tick(mk_tick(32767, -32768, 65535));
    send_tick(mk_tick(-32768, 32767, 65535));
    send_tick(mk_tick(1, 3, 1));
    wait_drained();
    // upper data bits must be dropped
    write_reg(ddo_pkg::REG_RADIUS, 32'hFFFF_FFFF);
    write_reg(ddo_pkg::REG_TRACK, 32'hFFFF_FFFF);
    send_tick(mk_tick(32767, 32767, 65535));
    send_tick(mk_tick(-32768, 32767, 65535));
    wait_drained();
    // zero track freezes heading
    write_reg(ddo_pkg::REG_TRACK, 32'h0000_0000);
    send_tick(mk_tick(-32768, 32767, 65535));
    send_tick(mk_tick(5000, 100, 30000));
    wait_drained();
    // zero radius still yields a result
    write_reg(ddo_pkg::REG_RADIUS, 32'h0000_0000);
    write_reg(ddo_pkg::REG_TRACK, 32'd180000);
    send_tick(mk_tick(32767, -32768, 65535));
    wait_drained();
    write_reg(REG_UNUSED, 32'h0000_1234);
    write_reg(ddo_pkg::REG_RADIUS, 32'd50000);
    send_tick(mk_tick(300, 900, 20000));
    wait_drained();
  endtask

  task automatic test_random_phase(input int n);
    write_reg(ddo_pkg::REG_RADIUS,
              $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(1000, 100000));
    write_reg(ddo_pkg::REG_TRACK,
              $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(50000, 400000));
    repeat (n) send_tick(rand_tick());
    wait_drained();
  endtask

  task automatic test_saturation();
    int sp;
    write_reg(ddo_pkg::REG_RADIUS, 32'd1048575);
    write_reg(ddo_pkg::REG_TRACK, 32'd1048575);
    repeat (300) begin
      sp = $urandom_range(30000, 32767);
      send_tick(mk_tick(sp, sp, $urandom_range(60000, 65535)));
    end
    repeat (40) send_tick(rand_tick());
    wait_drained();
  endtask

  task automatic test_backpressure();
    write_reg(ddo_pkg::REG_RADIUS, 32'd50000);
    write_reg(ddo_pkg::REG_TRACK, 32'd180000);
    hold_request = LONG_HOLD;
    repeat (10) send_tick(rand_tick());
    // sender pauses until everything is back, then resumes
    wait_drained();
    repeat (20) send_tick(rand_tick());
    wait_drained();
  endtask

  // receiver: random ready gaps and one long hold-off on request
  initial begin
    int gap;
    out_ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      gap = $urandom_range(0, 4);
      if ($urandom_range(0, 9) < 3) gap = 0;
      if (hold_request > 0) begin
        out_ready <= 1'b0;
        repeat (hold_request) @(posedge clk);
        hold_request = 0;
      end else if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  always @(posedge clk) begin
    ddo_pkg::out_word_t e;
    if (rst_n && out_valid && out_ready) begin
      if (pose_q.size() == 0) begin
        fail_count++;
        $display("unexpected result word %h", out_data);
      end else begin
        e = pose_q.pop_front();
        if (out_data.position_x_um !== e.position_x_um ||
            out_data.position_y_um !== e.position_y_um ||
            out_data.heading_angle !== e.heading_angle ||
            out_data.quat_w !== e.quat_w || out_data.quat_z !== e.quat_z) begin
          fail_count++;
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("mismatch x %0d/%0d y %0d/%0d hdg %0d/%0d w %0d/%0d z %0d/%0d",
                     e.position_x_um, out_data.position_x_um,
                     e.position_y_um, out_data.position_y_um,
                     e.heading_angle, out_data.heading_angle,
                     e.quat_w, out_data.quat_w, e.quat_z, out_data.quat_z);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    fail_count = 0;
    mismatch_count = 0;
    hold_request = 0;
    idle_cycles = 0;
    radius_um = 50000;
    track_um = 180000;
    pose_x = 0;
    pose_y = 0;
    pose_heading = '0;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_data <= '0;
    cfg_valid <= 1'b0;
    cfg_data <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_defaults();
    test_config_extremes();
    test_backpressure();
    repeat (4) test_random_phase(210);
    test_saturation();
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pose_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
`default_nettype wire

@@ sim.f @@
rtl/ddo_pkg.sv
rtl/diff_drive_odometry_core.sv
bench/diff_drive_odometry_core_tb.sv
